FILE: rtl/kabf_pkg.sv
// Package for the angle/gyro-bias Kalman filter: formats, step codes and
// saturation helpers. No dependencies.
package kabf_pkg;

  localparam int unsigned InDataW  = 80;
  localparam int unsigned OutDataW = 96;
  localparam int unsigned CfgAddrW = 2;
  localparam int unsigned MulBW    = 48;   // magnitude bits of the serial operand
  localparam int unsigned MulAW    = 63;   // magnitude bits of the parallel operand
  localparam int unsigned ProdW    = MulAW + MulBW;
  localparam int unsigned DivW     = 80;   // dividend bits: |n| << 32
  localparam int unsigned CntW     = 7;

  // configuration register indexes
  localparam logic [CfgAddrW-1:0] CFG_PN_ANGLE = 2'd0;
  localparam logic [CfgAddrW-1:0] CFG_PN_BIAS  = 2'd1;
  localparam logic [CfgAddrW-1:0] CFG_MEAS_N   = 2'd2;

  localparam logic [31:0] PN_ANGLE_RST = 32'd6442451;
  localparam logic [31:0] PN_BIAS_RST  = 32'd12884902;
  localparam logic [31:0] MEAS_N_RST   = 32'd128849019;

  localparam logic signed [63:0] LIM62 = 64'sh3FFF_FFFF_FFFF_FFFF;

  // sequencer steps
  typedef enum logic [3:0] {
    STP_ANGLE_PRED = 4'd1,
    STP_DT_PBB     = 4'd2,
    STP_PAA_PRED   = 4'd3,
    STP_PBB_PRED   = 4'd4,
    STP_GAIN0      = 4'd5,
    STP_GAIN1      = 4'd6,
    STP_ANGLE_CORR = 4'd7,
    STP_BIAS_CORR  = 4'd8,
    STP_PAA_CORR   = 4'd9,
    STP_PAB_CORR   = 4'd10,
    STP_PBA_CORR   = 4'd11,
    STP_PBB_CORR   = 4'd12
  } step_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_LOAD = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_DIV  = 6'b001000,
    ST_WB   = 6'b010000,
    ST_OUT  = 6'b100000
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) r = 32'sh7FFF_FFFF;
    else if (v < -66'sh0_8000_0000) r = -32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [65:0] v);
    logic signed [47:0] r;
    if (v > 66'sh0_7FFF_FFFF_FFFF) r = 48'sh7FFF_FFFF_FFFF;
    else if (v < -66'sh0_8000_0000_0000) r = -48'sh8000_0000_0000;
    else r = v[47:0];
    return r;
  endfunction

endpackage

FILE: rtl/kalman_angle_bias_filter_top.sv
// Two-state Kalman filter (angle, gyro bias) for one tilt axis.
// Flow: a load item goes through ST_OUT to the output register; an update item runs
//   12 steps of load, work and write-back (10 shift-add multiplies and 2 restoring
//   divisions; a non-positive S skips both divisions) before reaching ST_OUT.
// Items: one item at a time; a new item is taken only in ST_IDLE, after any wait
//   for the output register.
// Reset (rst_ni, async low): state and covariance zero, noise registers at defaults.
// Depends on kabf_pkg.
module kalman_angle_bias_filter_top import kabf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [24:0] measured_angle, [56:25] measured_rate, [77:57] step_time, [79:78] zero
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [0] op
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [31:0] angle_estimate, [63:32] corrected_rate, [95:64] bias_estimate
  output logic [OutDataW-1:0] m_axis_tdata,
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [31:0]         cfg_wdata_i
);

  state_e state_q;
  logic [3:0] step_q;
  logic [CntW-1:0] cnt_q;

  logic [31:0] pna_q, pnb_q, mn_q;
  logic signed [31:0] angle_q, bias_q, rate_q;
  logic signed [47:0] paa_q, pab_q, pba_q, pbb_q, p00_q, p01_q, inner_q;
  logic signed [63:0] tb_q, k0_q, k1_q;
  logic signed [24:0] meas_q;
  logic [20:0] dt_q;
  logic signed [32:0] y_q;
  logic signed [49:0] s_q;

  logic [ProdW-1:0] prod_q;
  logic [MulAW-1:0] mcand_q;
  logic sh32_q, neg_q;
  logic [DivW-1:0] dvd_q;
  logic [49:0] rem_q;

  logic m_valid_q;
  logic [OutDataW-1:0] m_data_q;

  logic in_xfer;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata = m_data_q;

  // operand selection per step
  logic signed [63:0] a_sel;
  logic signed [48:0] b_sel;
  logic signed [63:0] a_abs;
  logic signed [48:0] b_abs;
  logic signed [63:0] dt_s;
  logic is_div;
  logic signed [47:0] n_sel;
  logic signed [47:0] n_abs;

  always_comb begin
    dt_s = 64'($signed({1'b0, dt_q}));
    a_sel = dt_s;
    b_sel = 49'(rate_q);
    case (step_q)
      STP_ANGLE_PRED: begin a_sel = dt_s; b_sel = 49'(rate_q); end
      STP_DT_PBB:     begin a_sel = dt_s; b_sel = 49'(pbb_q); end
      STP_PAA_PRED:   begin a_sel = dt_s; b_sel = 49'(inner_q); end
      STP_PBB_PRED:   begin a_sel = dt_s; b_sel = 49'($signed({1'b0, pnb_q})); end
      STP_ANGLE_CORR: begin a_sel = k0_q; b_sel = 49'(y_q); end
      STP_BIAS_CORR:  begin a_sel = k1_q; b_sel = 49'(y_q); end
      STP_PAA_CORR:   begin a_sel = k0_q; b_sel = 49'(p00_q); end
      STP_PAB_CORR:   begin a_sel = k0_q; b_sel = 49'(p01_q); end
      STP_PBA_CORR:   begin a_sel = k1_q; b_sel = 49'(p00_q); end
      STP_PBB_CORR:   begin a_sel = k1_q; b_sel = 49'(p01_q); end
      default:        begin a_sel = dt_s; b_sel = 49'(rate_q); end
    endcase
    a_abs = a_sel[63] ? -a_sel : a_sel;
    b_abs = b_sel[48] ? -b_sel : b_sel;
    is_div = (step_q == STP_GAIN0) || (step_q == STP_GAIN1);
    n_sel = (step_q == STP_GAIN0) ? paa_q : pba_q;
    n_abs = n_sel[47] ? -n_sel : n_sel;
  end

  // multiplier result: floor shift, saturate to +-(2^62-1)
  logic [ProdW-1:0] p_sh;
  logic frac, msat;
  logic signed [63:0] mq, mres;
  always_comb begin
    p_sh = sh32_q ? (prod_q >> 32) : (prod_q >> 24);
    frac = sh32_q ? (|prod_q[31:0]) : (|prod_q[23:0]);
    msat = p_sh > ProdW'(LIM62);
    mq = $signed({1'b0, p_sh[62:0]});
    if (msat) mres = neg_q ? -LIM62 : LIM62;
    else if (neg_q) mres = -mq - 64'(frac);
    else mres = mq;
  end

  // divider result
  logic signed [63:0] dq, dres;
  always_comb begin
    dq = (|dvd_q[DivW-1:62]) ? LIM62 : $signed({2'b0, dvd_q[61:0]});
    dres = neg_q ? -dq : dq;
  end

  // one multiply step and one divide step
  logic [63:0] add_sum;
  logic [50:0] rem_sh;
  logic [50:0] rem_sub;
  always_comb begin
    add_sum = {1'b0, prod_q[ProdW-1:MulBW]} + {1'b0, mcand_q};
    rem_sh = {rem_q, dvd_q[DivW-1]};
    rem_sub = rem_sh - 51'($unsigned(s_q));
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pna_q <= PN_ANGLE_RST;
      pnb_q <= PN_BIAS_RST;
      mn_q  <= MEAS_N_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_PN_ANGLE: pna_q <= cfg_wdata_i;
        CFG_PN_BIAS:  pnb_q <= cfg_wdata_i;
        CFG_MEAS_N:   mn_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // sequencer and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q <= '0;
      cnt_q <= '0;
      angle_q <= '0;
      bias_q <= '0;
      rate_q <= '0;
      paa_q <= '0;
      pab_q <= '0;
      pba_q <= '0;
      pbb_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      // output transfer frees the register unless a new result is loaded
      if (m_valid_q && m_axis_tready && (state_q != ST_OUT)) m_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            meas_q <= $signed(s_axis_tdata[24:0]);
            dt_q <= s_axis_tdata[77:57];
            if (s_axis_tuser) begin
              angle_q <= 32'($signed(s_axis_tdata[24:0]));
              state_q <= ST_OUT;
            end else begin
              rate_q <= sat32(66'($signed(s_axis_tdata[56:25])) - 66'(bias_q));
              step_q <= STP_ANGLE_PRED;
              state_q <= ST_LOAD;
            end
          end
        end
        ST_LOAD: begin
          cnt_q <= '0;
          if (is_div) begin
            neg_q <= n_sel[47];
            dvd_q <= {n_abs, 32'b0};
            rem_q <= '0;
            if (s_q > 0) begin
              state_q <= ST_DIV;
            end else begin
              if (step_q == STP_GAIN0) k0_q <= '0;
              else k1_q <= '0;
              step_q <= step_q + 4'd1;
            end
          end else begin
            neg_q <= a_sel[63] ^ b_sel[48];
            mcand_q <= a_abs[MulAW-1:0];
            prod_q <= {{MulAW{1'b0}}, b_abs[MulBW-1:0]};
            sh32_q <= (step_q >= STP_ANGLE_CORR);
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (prod_q[0]) prod_q <= {add_sum, prod_q[MulBW-1:1]};
          else prod_q <= {1'b0, prod_q[ProdW-1:1]};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(MulBW - 1)) state_q <= ST_WB;
        end
        ST_DIV: begin
          if (!rem_sub[50]) begin
            rem_q <= rem_sub[49:0];
            dvd_q <= {dvd_q[DivW-2:0], 1'b1};
          end else begin
            rem_q <= rem_sh[49:0];
            dvd_q <= {dvd_q[DivW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(DivW - 1)) state_q <= ST_WB;
        end
        ST_WB: begin
          case (step_q)
            STP_ANGLE_PRED: angle_q <= sat32(66'(angle_q) + 66'(mres));
            STP_DT_PBB: begin
              tb_q <= mres;
              inner_q <= sat48(66'(sat48(66'(mres))) - 66'(pab_q) - 66'(pba_q)
                               + 66'($signed({1'b0, pna_q})));
            end
            STP_PAA_PRED: begin
              paa_q <= sat48(66'(paa_q) + 66'(mres));
              pab_q <= sat48(66'(pab_q) - 66'(tb_q));
              pba_q <= sat48(66'(pba_q) - 66'(tb_q));
            end
            STP_PBB_PRED: begin
              pbb_q <= sat48(66'(pbb_q) + 66'(mres));
              p00_q <= paa_q;
              p01_q <= pab_q;
              y_q <= 33'(meas_q) - 33'(angle_q);
              s_q <= 50'(paa_q) + 50'($signed({1'b0, mn_q}));
            end
            STP_GAIN0:      k0_q <= dres;
            STP_GAIN1:      k1_q <= dres;
            STP_ANGLE_CORR: angle_q <= sat32(66'(angle_q) + 66'(mres));
            STP_BIAS_CORR:  bias_q <= sat32(66'(bias_q) + 66'(mres));
            STP_PAA_CORR:   paa_q <= sat48(66'(paa_q) - 66'(mres));
            STP_PAB_CORR:   pab_q <= sat48(66'(pab_q) - 66'(mres));
            STP_PBA_CORR:   pba_q <= sat48(66'(pba_q) - 66'(mres));
            STP_PBB_CORR:   pbb_q <= sat48(66'(pbb_q) - 66'(mres));
            default: ;
          endcase
          if (step_q == STP_PBB_CORR) state_q <= ST_OUT;
          else begin
            step_q <= step_q + 4'd1;
            state_q <= ST_LOAD;
          end
        end
        ST_OUT: begin
          // wait for the output register to free up
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q <= {bias_q, rate_q, angle_q};
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
